/* src/u2d_pkg.sv */
package u2d_pkg;

  localparam int DIGIT_W = 4;
  localparam logic [5:0] ASCII_ZERO = 6'd48;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    logic capture;
    logic step;
    logic emit_load;
  } ctl_t;

  typedef struct packed {
    logic active;
  } stat_t;

endpackage

/* src/u2d_dabble.sv */
module u2d_dabble #(
  parameter int VALUE_BITS = 64,
  parameter int NDIG = 20
) (
  input  logic                        clk,
  input  u2d_pkg::ctl_t               ctl,
  input  logic [VALUE_BITS-1:0]       value,
  output logic [NDIG*u2d_pkg::DIGIT_W-1:0] bcd
);

  localparam int BCD_W = NDIG * u2d_pkg::DIGIT_W;

  logic [VALUE_BITS-1:0] bin_r;
  logic [VALUE_BITS-1:0] bin_nxt;
  logic [BCD_W-1:0]      bcd_r;
  logic [BCD_W-1:0]      bcd_nxt;
  logic [BCD_W-1:0]      adj;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*u2d_pkg::DIGIT_W +: u2d_pkg::DIGIT_W] >= 4'd5) begin
        adj[i*u2d_pkg::DIGIT_W +: u2d_pkg::DIGIT_W] =
          bcd_r[i*u2d_pkg::DIGIT_W +: u2d_pkg::DIGIT_W] + 4'd3;
      end else begin
        adj[i*u2d_pkg::DIGIT_W +: u2d_pkg::DIGIT_W] =
          bcd_r[i*u2d_pkg::DIGIT_W +: u2d_pkg::DIGIT_W];
      end
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    if (ctl.capture) begin
      bin_nxt = value;
      bcd_nxt = '0;
    end else if (ctl.step) begin
      bin_nxt = {bin_r[VALUE_BITS-2:0], 1'b0};
      bcd_nxt = {adj[BCD_W-2:0], bin_r[VALUE_BITS-1]};
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign bcd = bcd_r;

endmodule

/* src/u2d_emit.sv */
module u2d_emit #(
  parameter int NDIG = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  u2d_pkg::ctl_t                    ctl,
  input  logic [NDIG*u2d_pkg::DIGIT_W-1:0] bcd,
  output u2d_pkg::stat_t                   stat,
  output logic                             out_valid,
  output logic [5:0]                       out_digit_char,
  output logic                             out_last
);

  localparam int REM_W = $clog2(NDIG + 1);

  u2d_pkg::digit_t [NDIG-1:0] dig_r;
  u2d_pkg::digit_t [NDIG-1:0] dig_nxt;
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] rem_nxt;
  logic             started_r;
  logic             started_nxt;
  logic             act_r;
  logic             act_nxt;
  logic             valid_r;
  logic             valid_nxt;
  logic [5:0]       char_r;
  logic [5:0]       char_nxt;
  logic             last_r;
  logic             last_nxt;
  u2d_pkg::digit_t  top;

  assign top = dig_r[NDIG-1];

  always_comb begin
    dig_nxt     = dig_r;
    rem_nxt     = rem_r;
    started_nxt = started_r;
    act_nxt     = act_r;
    valid_nxt   = 1'b0;
    char_nxt    = char_r;
    last_nxt    = 1'b0;
    if (ctl.emit_load) begin
      dig_nxt     = bcd;
      rem_nxt     = REM_W'(NDIG);
      started_nxt = 1'b0;
      act_nxt     = 1'b1;
    end else if (act_r) begin
      dig_nxt = {dig_r[NDIG-2:0], u2d_pkg::digit_t'(0)};
      rem_nxt = rem_r - REM_W'(1);
      if (started_r || top != '0 || rem_r == REM_W'(1)) begin
        valid_nxt   = 1'b1;
        char_nxt    = u2d_pkg::ASCII_ZERO + {2'b00, top};
        last_nxt    = (rem_r == REM_W'(1));
        started_nxt = 1'b1;
      end
      if (rem_r == REM_W'(1)) begin
        act_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dig_r   <= dig_nxt;
    rem_r   <= rem_nxt;
    char_r  <= char_nxt;
    last_r  <= last_nxt;
    started_r <= started_nxt;
    if (!rst_n) begin
      act_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      act_r   <= act_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign stat.active    = act_r;
  assign out_valid      = valid_r;
  assign out_digit_char = char_r;
  assign out_last       = last_r & valid_r;

endmodule

/* src/u64_to_decimal_digits_top.sv */
// Each value is converted by shift-and-add-3, one bit per cycle.
// A load state follows, then the digit shifter walks all decimal places, one per cycle.
// busy stays high through the CONV, LOAD and EMIT states; start is taken only in IDLE.
// The receiver cannot stall; a synchronous active-low reset clears the FSM state
// and the emitter's active and valid flags.
module u64_to_decimal_digits_top #(
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_value,
  output logic        out_valid,
  output logic [5:0]  out_digit_char,
  output logic        out_last
);

  localparam int NDIG  = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int CNT_W = $clog2(VALUE_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_LOAD,
    ST_EMIT
  } state_t;

  state_t           state_r;
  state_t           state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  u2d_pkg::ctl_t    ctl;
  u2d_pkg::stat_t   stat;
  logic [NDIG*u2d_pkg::DIGIT_W-1:0] bcd;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ctl.capture   = 1'b0;
    ctl.step      = 1'b0;
    ctl.emit_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        ctl.step = 1'b1;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(VALUE_BITS - 1)) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ctl.emit_load = 1'b1;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat.active) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  u2d_dabble #(
    .VALUE_BITS(VALUE_BITS),
    .NDIG(NDIG)
  ) u_dabble (
    .clk(clk),
    .ctl(ctl),
    .value(in_value[VALUE_BITS-1:0]),
    .bcd(bcd)
  );

  u2d_emit #(
    .NDIG(NDIG)
  ) u_emit (
    .clk(clk),
    .rst_n(rst_n),
    .ctl(ctl),
    .bcd(bcd),
    .stat(stat),
    .out_valid(out_valid),
    .out_digit_char(out_digit_char),
    .out_last(out_last)
  );

endmodule

/* src/u2d_checker.sv */
module u2d_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [5:0] out_digit_char,
  input logic       out_last
);

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= 6'd48 && out_digit_char <= 6'd57))
    else $error("digit beat outside the ASCII digit range");

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("last flag without a digit beat");

  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> out_valid)
    else $error("gap inside a digit run");

  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted value did not start a quiet conversion");

endmodule

bind u64_to_decimal_digits_top u2d_checker u_chk (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .out_valid(out_valid),
  .out_digit_char(out_digit_char),
  .out_last(out_last)
);
